// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; defining NO_ASSERTIONS drops them all.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed: ante -> cons");
// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed: ante => cons");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/rgbvpp_pkg.sv -----
// Types, register map and helpers for the RGB888 true-colour pixel packer.
package rgbvpp_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_RED_MASK   = 3'd0;
	localparam logic [2:0] REG_GREEN_MASK = 3'd1;
	localparam logic [2:0] REG_BLUE_MASK  = 3'd2;
	localparam logic [2:0] REG_BIG_ENDIAN = 3'd3;
	localparam logic [2:0] REG_WIDE_MODE  = 3'd4;

	localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

	localparam logic [2:0] BYTES_NARROW = 3'd2;
	localparam logic [2:0] BYTES_WIDE   = 3'd4;

	typedef struct packed {
		logic [7:0] red_value;
		logic [7:0] green_value;
		logic [7:0] blue_value;
		logic       last_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [7:0] fourth_byte;
		logic [2:0] byte_count;
		logic       last_out;
	} pix_out_t;

	// Right shift that drops bit 7 of {value, 24'h0} onto the mask's top bit:
	// 31 - top bit position. An empty mask gives 0; the AND clears it anyway.
	function automatic logic [4:0] align_shift(input logic [31:0] mask);
		logic [4:0] sh;
		sh = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mask[i]) begin
				sh = 5'(31 - i);
			end
		end
		return sh;
	endfunction

endpackage

// ----- rtl/core/rgb888_to_visual_pixel_packer.sv -----
// Top level of the RGB888 to true-colour pixel packer.
//
// Takes one RGB888 pixel per request and returns the packed true-colour pixel as
// four memory-order bytes plus a byte count (2 in 16-bit mode, 4 in wide mode) and
// the end-of-image flag. Each channel is moved so that its bit 7 lands on the top
// set bit of its mask (parked at the top of the word, then shifted right), ANDed
// with the mask, and the three channels ORed together; an empty mask contributes
// nothing. In 16-bit mode only the low half-word is sent and the third and fourth
// bytes are zero. Throughput is one pixel per clock while res_stall does not hold
// the pipeline; each pixel passes through the input register and then the result
// register. pix_stall rises only when both stages hold a pixel and res_stall is
// high. The alignment shift is worked out from the mask when the mask register is
// written, so the datapath is three 32-bit shifters, an AND/OR and a byte swap.
// Registers: 0x00 red mask, 0x04 green mask, 0x08 blue mask, 0x0C big-endian order
// (bit 0), 0x10 wide pixel mode (bit 0). Write them only while no pixel is in flight.
module rgb888_to_visual_pixel_packer
	import rgbvpp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// pixel requests in
	input  logic              pix_valid,
	output logic              pix_stall,
	input  pix_in_t           pix_data,
	// packed pixels out
	output logic              res_valid,
	input  logic              res_stall,
	output pix_out_t          res_data
);

`include "assert_macros.svh"

	// ---------------------------------------------------------------- config
	logic [31:0] red_bits_q, green_bits_q, blue_bits_q;
	logic [4:0]  red_sh_q, green_sh_q, blue_sh_q;
	logic        big_endian_q, wide_mode_q;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_bits_q   <= RED_MASK_RST;
			green_bits_q <= GREEN_MASK_RST;
			blue_bits_q  <= BLUE_MASK_RST;
			red_sh_q     <= align_shift(RED_MASK_RST);
			green_sh_q   <= align_shift(GREEN_MASK_RST);
			blue_sh_q    <= align_shift(BLUE_MASK_RST);
			big_endian_q <= 1'b0;
			wide_mode_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RED_MASK: begin
					red_bits_q <= pwdata;
					red_sh_q   <= align_shift(pwdata);
				end
				REG_GREEN_MASK: begin
					green_bits_q <= pwdata;
					green_sh_q   <= align_shift(pwdata);
				end
				REG_BLUE_MASK: begin
					blue_bits_q <= pwdata;
					blue_sh_q   <= align_shift(pwdata);
				end
				REG_BIG_ENDIAN: big_endian_q <= pwdata[0];
				REG_WIDE_MODE:  wide_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RED_MASK:   prdata = red_bits_q;
			REG_GREEN_MASK: prdata = green_bits_q;
			REG_BLUE_MASK:  prdata = blue_bits_q;
			REG_BIG_ENDIAN: prdata = {31'h0, big_endian_q};
			REG_WIDE_MODE:  prdata = {31'h0, wide_mode_q};
			default:        prdata = '0;
		endcase
	end

	// -------------------------------------------------------------- pipeline
	logic     v_s1, v_s2;
	pix_in_t  pix_s1;
	pix_out_t res_s2;
	logic     adv_s2, adv_s1;

	// a stage loads when it is empty or its contents move on this cycle
	assign adv_s2    = !v_s2 || !res_stall;
	assign adv_s1    = !v_s1 || adv_s2;
	assign pix_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= pix_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_valid) pix_s1 <= pix_data;
	end

	// ------------------------------------------------------- pack (s1 -> s2)
	logic [31:0] red_w, green_w, blue_w, word;
	pix_out_t    packed_d;

	rgbvpp_chan_place u_red (
		.value  (pix_s1.red_value),
		.mask   (red_bits_q),
		.rsh    (red_sh_q),
		.placed (red_w)
	);

	rgbvpp_chan_place u_green (
		.value  (pix_s1.green_value),
		.mask   (green_bits_q),
		.rsh    (green_sh_q),
		.placed (green_w)
	);

	rgbvpp_chan_place u_blue (
		.value  (pix_s1.blue_value),
		.mask   (blue_bits_q),
		.rsh    (blue_sh_q),
		.placed (blue_w)
	);

	assign word = red_w | green_w | blue_w;

	always_comb begin
		packed_d.last_out = pix_s1.last_pixel;
		if (wide_mode_q) begin
			packed_d.byte_count = BYTES_WIDE;
			if (big_endian_q) begin
				packed_d.first_byte  = word[31:24];
				packed_d.second_byte = word[23:16];
				packed_d.third_byte  = word[15:8];
				packed_d.fourth_byte = word[7:0];
			end else begin
				packed_d.first_byte  = word[7:0];
				packed_d.second_byte = word[15:8];
				packed_d.third_byte  = word[23:16];
				packed_d.fourth_byte = word[31:24];
			end
		end else begin
			// 16-bit pixel: low half-word only
			packed_d.byte_count  = BYTES_NARROW;
			packed_d.third_byte  = 8'h00;
			packed_d.fourth_byte = 8'h00;
			if (big_endian_q) begin
				packed_d.first_byte  = word[15:8];
				packed_d.second_byte = word[7:0];
			end else begin
				packed_d.first_byte  = word[7:0];
				packed_d.second_byte = word[15:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) res_s2 <= packed_d;
	end

	assign res_valid = v_s2;
	assign res_data  = res_s2;

	// ------------------------------------------------------------ assertions
	// input only backs up when both stages are occupied
	`ASSERT_IMPLIES(a_stall_full, pix_stall, v_s1 && v_s2 && res_stall)
	// an accepted pixel is held in the input register next cycle
	`ASSERT_NEXT(a_accept_s1, pix_valid && !pix_stall, v_s1)
	// the byte count agrees with the zeroed upper bytes of a 16-bit pixel
	`ASSERT_IMPLIES(a_narrow_zero,
		res_valid && res_data.byte_count == BYTES_NARROW,
		res_data.third_byte == 8'h00 && res_data.fourth_byte == 8'h00)
	// every pixel carries one of the two legal byte counts
	`ASSERT_IMPLIES(a_count_legal, res_valid,
		res_data.byte_count == BYTES_NARROW || res_data.byte_count == BYTES_WIDE)

endmodule

// ----- rtl/core/rgbvpp_chan_place.sv -----
// Aligns one 8-bit colour channel to its mask inside the 32-bit pixel word.
module rgbvpp_chan_place
	import rgbvpp_pkg::*;
(
	input  logic [7:0]  value,
	input  logic [31:0] mask,
	input  logic [4:0]  rsh,
	output logic [31:0] placed
);

	logic [31:0] top_aligned;

	// channel parked at the top of the word, then moved down to the mask
	assign top_aligned = {value, 24'h00_0000} >> rsh;
	assign placed      = top_aligned & mask;

endmodule
